>>> rtl/core/owd_pkg.sv
// Shared types and constants of the one-wire dimming frame transmitter.
// Holds command codes, register indexes, reset values and the beat structures.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package owd_pkg;

    // Widths fixed by the register map and the beat fields.
    localparam int CFG_TIME_W = 12;
    localparam int CFG_ADDR_W = 8;
    localparam int BRIGHT_W   = 8;
    localparam int LEVEL_W    = 5;
    localparam int CFG_IDX_W  = 3;

    // Brightness to level mapping: level = ((b - LEVEL_FLOOR) >> LEVEL_SHIFT) + 1.
    localparam logic [BRIGHT_W-1:0] LEVEL_FLOOR = 8'd15;
    localparam int                  LEVEL_SHIFT = 3;

    // Register reset values.
    localparam logic [CFG_TIME_W-1:0] SHORT_RESET  = 12'd180;
    localparam logic [CFG_TIME_W-1:0] LONG_RESET   = 12'd360;
    localparam logic [CFG_TIME_W-1:0] EOS_RESET    = 12'd300;
    localparam logic [CFG_TIME_W-1:0] DELAY_RESET  = 12'd150;
    localparam logic [CFG_TIME_W-1:0] DLOW_RESET   = 12'd500;
    localparam logic [CFG_TIME_W-1:0] WINDOW_RESET = 12'd3500;
    localparam logic [CFG_TIME_W-1:0] GAP_RESET    = 12'd10;
    localparam logic [CFG_ADDR_W-1:0] ADDR_RESET   = 8'h1A;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET     = 2'd1,
        OP_SUSPEND = 2'd2,
        OP_RESUME  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT   = 3'd0,
        REG_LONG    = 3'd1,
        REG_EOS     = 3'd2,
        REG_DELAY   = 3'd3,
        REG_DLOW    = 3'd4,
        REG_WINDOW  = 3'd5,
        REG_GAP     = 3'd6,
        REG_ADDRESS = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_TIME_W-1:0] short_time;
        logic [CFG_TIME_W-1:0] long_time;
        logic [CFG_TIME_W-1:0] eos_time;
        logic [CFG_TIME_W-1:0] delay_time;
        logic [CFG_TIME_W-1:0] dlow_time;
        logic [CFG_TIME_W-1:0] window_time;
        logic [CFG_TIME_W-1:0] gap_time;
        logic [CFG_ADDR_W-1:0] address;
    } cfg_t;

    typedef struct packed {
        op_t                 op;
        logic [BRIGHT_W-1:0] brightness;
        logic                blanked;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] sent_level;
        logic               busy_res;
        logic               accepted;
        logic               pin;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/owd_segment.sv
// Segment decoder: line level and duration in ticks of one frame segment.
// Depends on owd_pkg for the register structure.
`default_nettype none

module owd_segment #(
    parameter int ADDRESS_BITS = 8,
    parameter int DATA_BITS    = 8,
    parameter int TIMER_WIDTH  = 12,
    parameter int IDX_W        = 6
) (
    input  wire  [IDX_W-1:0]       seg,
    input  owd_pkg::cfg_t          cfg,
    input  wire  [DATA_BITS-1:0]   level_bits,
    output logic                   seg_level,
    output logic [TIMER_WIDTH-1:0] seg_len
);

    localparam int A_END  = 4 + 2 * ADDRESS_BITS;
    localparam int D_BEG  = A_END + 2;
    localparam int D_END  = D_BEG + 2 * DATA_BITS;
    localparam int DPOS_W = $clog2(DATA_BITS);

    logic [owd_pkg::CFG_TIME_W-1:0] raw;
    logic [IDX_W-1:0]               rel;
    logic [IDX_W-1:0]               k;
    logic [IDX_W-1:0]               pos;
    logic                           data_bit;
    logic [TIMER_WIDTH-1:0]         len_raw;

    always_comb
    begin
        raw       = cfg.eos_time;
        seg_level = 1'b0;
        rel       = '0;
        k         = '0;
        pos       = '0;
        data_bit  = 1'b0;
        if (seg == IDX_W'(0))
        begin
            raw = cfg.eos_time;
        end
        else if (seg == IDX_W'(1))
        begin
            seg_level = 1'b1;
            raw       = cfg.delay_time;
        end
        else if (seg == IDX_W'(2))
        begin
            raw = cfg.dlow_time;
        end
        else if (seg == IDX_W'(3))
        begin
            seg_level = 1'b1;
            raw       = cfg.window_time;
        end
        else if (seg < IDX_W'(A_END))
        begin
            // Address bits, least significant first; bits above the byte are zero.
            rel       = seg - IDX_W'(4);
            k         = rel >> 1;
            data_bit  = (k < IDX_W'(owd_pkg::CFG_ADDR_W)) ? cfg.address[k[2:0]] : 1'b0;
            seg_level = seg[0];
            raw       = (data_bit ^ seg[0]) ? cfg.short_time : cfg.long_time;
        end
        else if (seg == IDX_W'(A_END))
        begin
            raw = cfg.eos_time;
        end
        else if (seg == IDX_W'(A_END + 1))
        begin
            seg_level = 1'b1;
            raw       = cfg.gap_time;
        end
        else if (seg < IDX_W'(D_END))
        begin
            // Level bits, most significant first.
            rel       = seg - IDX_W'(D_BEG);
            k         = rel >> 1;
            pos       = IDX_W'(DATA_BITS - 1) - k;
            data_bit  = level_bits[pos[DPOS_W-1:0]];
            seg_level = seg[0];
            raw       = (data_bit ^ seg[0]) ? cfg.short_time : cfg.long_time;
        end
        else
        begin
            raw = cfg.eos_time;
        end
    end

    // A duration of zero counts as one tick.
    assign len_raw = TIMER_WIDTH'(raw);
    assign seg_len = (len_raw == '0) ? TIMER_WIDTH'(1) : len_raw;

endmodule

`default_nettype wire

>>> rtl/core/owd_engine.sv
// Frame engine: command handling, power state and the segment timer.
// Depends on owd_pkg and owd_segment; one step per enabled cycle.
`default_nettype none

module owd_engine #(
    parameter int ADDRESS_BITS = 8,
    parameter int DATA_BITS    = 8,
    parameter int LEVEL_COUNT  = 32,
    parameter int TIMER_WIDTH  = 12
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              step_en,
    input  owd_pkg::item_t   item,
    input  owd_pkg::cfg_t    cfg,
    output owd_pkg::result_t result
);

    localparam int D_END = 4 + 2 * ADDRESS_BITS + 2 + 2 * DATA_BITS;
    localparam int IDX_W = $clog2(D_END + 1);
    localparam logic [owd_pkg::LEVEL_W-1:0] LEVEL_MAX = owd_pkg::LEVEL_W'(LEVEL_COUNT - 1);

    logic                            line_reg, line_next;
    logic                            sending_reg, sending_next;
    logic [IDX_W-1:0]                seg_reg, seg_next;
    logic [TIMER_WIDTH-1:0]          ticks_reg, ticks_next;
    logic [DATA_BITS-1:0]            level_bits_reg, level_bits_next;
    logic                            powered_reg, powered_next;
    logic [owd_pkg::BRIGHT_W-1:0]    wake_reg, wake_next;
    logic [owd_pkg::LEVEL_W-1:0]     last_level_reg, last_level_next;

    logic [IDX_W-1:0]                lookup_idx;
    logic                            lookup_level;
    logic [TIMER_WIDTH-1:0]          lookup_len;

    // While idle the decoder serves segment zero for a new frame; during a
    // frame it serves the following segment.
    assign lookup_idx = sending_reg ? (seg_reg + IDX_W'(1)) : '0;

    owd_segment #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .DATA_BITS    (DATA_BITS),
        .TIMER_WIDTH  (TIMER_WIDTH),
        .IDX_W        (IDX_W)
    ) u_segment (
        .seg        (lookup_idx),
        .cfg        (cfg),
        .level_bits (level_bits_reg),
        .seg_level  (lookup_level),
        .seg_len    (lookup_len)
    );

    always_comb
    begin
        logic [owd_pkg::BRIGHT_W-1:0] bright;
        logic                         do_apply;
        logic [owd_pkg::BRIGHT_W-1:0] lvl_wide;
        logic [owd_pkg::LEVEL_W-1:0]  lvl;

        line_next       = line_reg;
        sending_next    = sending_reg;
        seg_next        = seg_reg;
        ticks_next      = ticks_reg;
        level_bits_next = level_bits_reg;
        powered_next    = powered_reg;
        wake_next       = wake_reg;
        last_level_next = last_level_reg;
        result.accepted = 1'b0;
        bright          = '0;
        do_apply        = 1'b0;

        if (item.op == owd_pkg::OP_TICK)
        begin
            if (sending_reg)
            begin
                if (ticks_reg > TIMER_WIDTH'(1))
                begin
                    ticks_next = ticks_reg - TIMER_WIDTH'(1);
                end
                else if (seg_reg == IDX_W'(D_END))
                begin
                    line_next    = 1'b1;
                    sending_next = 1'b0;
                    ticks_next   = '0;
                    seg_next     = '0;
                end
                else
                begin
                    seg_next   = lookup_idx;
                    line_next  = lookup_level;
                    ticks_next = lookup_len;
                end
            end
        end
        else if (!sending_reg)
        begin
            result.accepted = 1'b1;
            case (item.op)
                owd_pkg::OP_SET:
                begin
                    bright    = item.blanked ? '0 : item.brightness;
                    wake_next = bright;
                    do_apply  = powered_reg;
                end
                owd_pkg::OP_SUSPEND:
                begin
                    powered_next = 1'b0;
                    do_apply     = 1'b1;
                end
                owd_pkg::OP_RESUME:
                begin
                    bright       = wake_reg;
                    powered_next = 1'b1;
                    do_apply     = 1'b1;
                end
                default:
                begin
                    do_apply = 1'b0;
                end
            endcase
        end

        lvl_wide = (bright < owd_pkg::LEVEL_FLOOR) ? '0 :
                   (((bright - owd_pkg::LEVEL_FLOOR) >> owd_pkg::LEVEL_SHIFT)
                    + owd_pkg::BRIGHT_W'(1));
        lvl      = (lvl_wide[owd_pkg::LEVEL_W-1:0] > LEVEL_MAX) ? LEVEL_MAX
                                                                : lvl_wide[owd_pkg::LEVEL_W-1:0];

        if (do_apply)
        begin
            line_next = 1'b0;
            if (bright != '0)
            begin
                last_level_next = lvl;
                level_bits_next = DATA_BITS'(lvl);
                seg_next        = '0;
                sending_next    = 1'b1;
                ticks_next      = lookup_len;
            end
        end

        result.pin        = line_next;
        result.busy_res   = sending_next;
        result.sent_level = last_level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg       <= 1'b0;
            sending_reg    <= 1'b0;
            seg_reg        <= '0;
            ticks_reg      <= '0;
            level_bits_reg <= '0;
            powered_reg    <= 1'b1;
            wake_reg       <= '0;
            last_level_reg <= '0;
        end
        else if (step_en)
        begin
            line_reg       <= line_next;
            sending_reg    <= sending_next;
            seg_reg        <= seg_next;
            ticks_reg      <= ticks_next;
            level_bits_reg <= level_bits_next;
            powered_reg    <= powered_next;
            wake_reg       <= wake_next;
            last_level_reg <= last_level_next;
        end
    end

    // An idle line never leaves a stale count or segment behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (ticks_reg == '0 && seg_reg == '0))
    else $error("idle engine holds a nonzero timer or segment");

    // Every segment of a running frame lasts at least one tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        sending_reg |-> ticks_reg != '0)
    else $error("running frame with an empty segment timer");

    // The segment index stays within the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        sending_reg |-> seg_reg <= IDX_W'(D_END))
    else $error("segment index ran past the end of the frame");

    // A step during a frame either keeps it running or ends it with the line
    // released high and the timer cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && sending_reg) |=> sending_reg || (line_reg && ticks_reg == '0))
    else $error("frame ended without releasing the line high");

endmodule

`default_nettype wire

>>> rtl/core/one_wire_dimming_frame_tx.sv
// Top level of the one-wire dimming frame transmitter.
// Depends on owd_pkg and owd_engine (which uses owd_segment).
`default_nettype none

// Usage
// The block drives one dimming control line. Commands arrive on the s_axis
// channel, one beat per command: tuser carries the command code (tick, set
// brightness, suspend, resume) and tdata the brightness and blank flag. A tick
// advances the line timer by one step; the other commands change brightness
// or power, and are refused while a frame is on the line. Every input beat
// produces exactly one m_axis beat with the line level after the step, the
// accept flag, the busy flag and the level of the latest frame started.
// Timing registers and the device address are written through the cfg
// channel (index plus data), which is always ready; write it only while idle.
// An accepted input beat goes into the input register, then through the
// engine into the result register. Throughput is one beat per cycle while
// the receiver takes results; a single engine step lies between those two
// registers. When the receiver stalls, the result register holds its beat and
// the input register still takes one more beat; after that s_axis_tready
// drops until the result is taken.
// Reset empties both registers, loads the register defaults, drives the line
// low with power on and no frame running.

module one_wire_dimming_frame_tx #(
    parameter int ADDRESS_BITS = 8,
    parameter int DATA_BITS    = 8,
    parameter int LEVEL_COUNT  = 32,
    parameter int TIMER_WIDTH  = 12
) (
    input  wire         clk,
    input  wire         rst_n,
    // Command stream.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,  // [7:0] brightness, [8] blanked, rest zero
    input  wire  [1:0]  s_axis_tuser,  // [1:0] op
    // Result stream.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [0] pin, [1] accepted, [2] busy_res, [7:3] sent_level
    // Register writes.
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [11:0] cfg_data
);

    owd_pkg::cfg_t    cfg_reg, cfg_next;
    logic             item_valid_reg, item_valid_next;
    owd_pkg::item_t   item_reg, item_next;
    logic             res_valid_reg, res_valid_next;
    owd_pkg::result_t res_reg;
    owd_pkg::result_t step_result;
    logic             step_en;
    logic             in_beat;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (owd_pkg::cfg_idx_t'(cfg_index))
                owd_pkg::REG_SHORT:   cfg_next.short_time  = cfg_data;
                owd_pkg::REG_LONG:    cfg_next.long_time   = cfg_data;
                owd_pkg::REG_EOS:     cfg_next.eos_time    = cfg_data;
                owd_pkg::REG_DELAY:   cfg_next.delay_time  = cfg_data;
                owd_pkg::REG_DLOW:    cfg_next.dlow_time   = cfg_data;
                owd_pkg::REG_WINDOW:  cfg_next.window_time = cfg_data;
                owd_pkg::REG_GAP:     cfg_next.gap_time    = cfg_data;
                owd_pkg::REG_ADDRESS: cfg_next.address     = cfg_data[owd_pkg::CFG_ADDR_W-1:0];
                default:              cfg_next             = cfg_reg;
            endcase
        end
    end

    // The engine steps when an item waits and the result register is free
    // or being emptied in this cycle.
    assign step_en       = item_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || step_en;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item_next.op         = owd_pkg::op_t'(s_axis_tuser);
        item_next.brightness = s_axis_tdata[owd_pkg::BRIGHT_W-1:0];
        item_next.blanked    = s_axis_tdata[owd_pkg::BRIGHT_W];
        if (in_beat)
        begin
            item_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
        if (step_en)
        begin
            res_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    owd_engine #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .DATA_BITS    (DATA_BITS),
        .LEVEL_COUNT  (LEVEL_COUNT),
        .TIMER_WIDTH  (TIMER_WIDTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_time  <= owd_pkg::SHORT_RESET;
            cfg_reg.long_time   <= owd_pkg::LONG_RESET;
            cfg_reg.eos_time    <= owd_pkg::EOS_RESET;
            cfg_reg.delay_time  <= owd_pkg::DELAY_RESET;
            cfg_reg.dlow_time   <= owd_pkg::DLOW_RESET;
            cfg_reg.window_time <= owd_pkg::WINDOW_RESET;
            cfg_reg.gap_time    <= owd_pkg::GAP_RESET;
            cfg_reg.address     <= owd_pkg::ADDR_RESET;
            item_valid_reg      <= 1'b0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            item_reg <= item_next;
        end
        if (step_en)
        begin
            res_reg <= step_result;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = res_reg;

endmodule

`default_nettype wire

>>> bench/tb_one_wire_dimming_frame_tx.sv
// Self-checking bench for the one-wire dimming frame transmitter.
// Drives command beats, checks every result beat against a line model of its own.
// Depends on owd_pkg and the one_wire_dimming_frame_tx RTL.
`timescale 1ns / 100ps

module tb_one_wire_dimming_frame_tx;

    // Frame geometry of the default build.
    localparam int ADDR_BITS   = 8;
    localparam int LEVEL_BITS  = 8;
    localparam int TOP_LEVEL   = 31;
    localparam int ADDR_END    = 4 + 2 * ADDR_BITS;
    localparam int DATA_BEGIN  = ADDR_END + 2;
    localparam int DATA_END    = DATA_BEGIN + 2 * LEVEL_BITS;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASE_ITEMS  = 200;

    // One segment of a frame: line level and length in ticks.
    typedef struct packed {
        logic        present;
        logic        level;
        logic [11:0] len;
    } segment_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] brightness, [8] blanked, rest zero
    logic [1:0]  s_axis_tuser = '0;   // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [0] pin, [1] accepted, [2] busy_res, [7:3] sent_level
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    one_wire_dimming_frame_tx i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line model. It holds its own copy of the timing registers and of the
    // frame state, and is stepped once for every command beat accepted.
    // ------------------------------------------------------------------
    logic [11:0] cfg_regs [8];
    logic        line_pin;
    logic        frame_busy;
    int          seg_num;
    logic [11:0] seg_ticks;
    logic [7:0]  frame_level;
    logic        powered;
    logic [7:0]  wake_bright;
    logic [4:0]  latest_level;

    // A duration register written as zero still lasts one tick.
    function automatic int ticks_of(input logic [11:0] v);
        return (v == 12'd0) ? 1 : int'(v);
    endfunction

    // Upper bound on the ticks one frame takes with the current timing.
    function automatic int frame_span();
        return 3 * ticks_of(cfg_regs[owd_pkg::REG_EOS]) + ticks_of(cfg_regs[owd_pkg::REG_DELAY])
             + ticks_of(cfg_regs[owd_pkg::REG_DLOW]) + ticks_of(cfg_regs[owd_pkg::REG_WINDOW])
             + ticks_of(cfg_regs[owd_pkg::REG_GAP])
             + (ADDR_BITS + LEVEL_BITS)
               * (ticks_of(cfg_regs[owd_pkg::REG_SHORT])
                  + ticks_of(cfg_regs[owd_pkg::REG_LONG])) + 1;
    endfunction

    function automatic segment_t segment_at(input int s);
        segment_t seg;
        int       k;
        logic     half;
        logic     bit_val;
        seg.present = 1'b1;
        seg.level   = 1'b0;
        seg.len     = 12'd1;
        if (s == 0)
        begin
            seg.len = 12'(ticks_of(cfg_regs[owd_pkg::REG_EOS]));
        end
        else if (s == 1)
        begin
            seg.level = 1'b1;
            seg.len   = 12'(ticks_of(cfg_regs[owd_pkg::REG_DELAY]));
        end
        else if (s == 2)
        begin
            seg.len = 12'(ticks_of(cfg_regs[owd_pkg::REG_DLOW]));
        end
        else if (s == 3)
        begin
            seg.level = 1'b1;
            seg.len   = 12'(ticks_of(cfg_regs[owd_pkg::REG_WINDOW]));
        end
        else if (s == ADDR_END || s == DATA_END)
        begin
            seg.len = 12'(ticks_of(cfg_regs[owd_pkg::REG_EOS]));
        end
        else if (s == ADDR_END + 1)
        begin
            seg.level = 1'b1;
            seg.len   = 12'(ticks_of(cfg_regs[owd_pkg::REG_GAP]));
        end
        else if (s > DATA_END)
        begin
            seg.present = 1'b0;
        end
        else
        begin
            // Address bits go out LSB first, the level MSB first. Each bit is
            // a low half then a high half; a one has the short half low.
            if (s < ADDR_END)
            begin
                k       = (s - 4) >> 1;
                half    = 1'((s - 4) & 1);
                bit_val = cfg_regs[owd_pkg::REG_ADDRESS][k];
            end
            else
            begin
                k       = (s - DATA_BEGIN) >> 1;
                half    = 1'((s - DATA_BEGIN) & 1);
                bit_val = frame_level[LEVEL_BITS - 1 - k];
            end
            seg.level = half;
            if (bit_val ^ half)
                seg.len = 12'(ticks_of(cfg_regs[owd_pkg::REG_SHORT]));
            else
                seg.len = 12'(ticks_of(cfg_regs[owd_pkg::REG_LONG]));
        end
        return seg;
    endfunction

    function automatic void start_brightness(input logic [7:0] b);
        int lvl;
        if (b == 8'd0)
        begin
            // Zero pulls the line low at once and sends nothing.
            line_pin = 1'b0;
            return;
        end
        lvl = (b < owd_pkg::LEVEL_FLOOR) ? 0
            : ((int'(b) - int'(owd_pkg::LEVEL_FLOOR)) >> owd_pkg::LEVEL_SHIFT) + 1;
        if (lvl > TOP_LEVEL)
            lvl = TOP_LEVEL;
        latest_level = lvl[4:0];
        frame_level  = lvl[7:0];
        seg_num      = 0;
        frame_busy   = 1'b1;
        line_pin     = 1'b0;
        seg_ticks    = 12'(ticks_of(cfg_regs[owd_pkg::REG_EOS]));
    endfunction

    function automatic void advance_line();
        segment_t seg;
        if (seg_ticks > 12'd1)
        begin
            seg_ticks--;
            return;
        end
        seg_num++;
        seg = segment_at(seg_num);
        if (seg.present)
        begin
            line_pin  = seg.level;
            seg_ticks = seg.len;
        end
        else
        begin
            // Frame done: the line rests high.
            line_pin   = 1'b1;
            frame_busy = 1'b0;
            seg_ticks  = '0;
            seg_num    = 0;
        end
    endfunction

    function automatic owd_pkg::result_t line_step(input owd_pkg::item_t c);
        owd_pkg::result_t r;
        logic             taken;
        taken = 1'b0;
        if (c.op == owd_pkg::OP_TICK)
        begin
            if (frame_busy)
                advance_line();
        end
        else if (!frame_busy)
        begin
            taken = 1'b1;
            case (c.op)
                owd_pkg::OP_SET:
                begin
                    wake_bright = c.blanked ? 8'd0 : c.brightness;
                    if (powered)
                        start_brightness(wake_bright);
                end
                owd_pkg::OP_SUSPEND:
                begin
                    powered = 1'b0;
                    start_brightness(8'd0);
                end
                default:
                begin
                    start_brightness(wake_bright);
                    powered = 1'b1;
                end
            endcase
        end
        r.pin        = line_pin;
        r.accepted   = taken;
        r.busy_res   = frame_busy;
        r.sent_level = latest_level;
        return r;
    endfunction

    function automatic void reset_line_model();
        cfg_regs[owd_pkg::REG_SHORT]   = owd_pkg::SHORT_RESET;
        cfg_regs[owd_pkg::REG_LONG]    = owd_pkg::LONG_RESET;
        cfg_regs[owd_pkg::REG_EOS]     = owd_pkg::EOS_RESET;
        cfg_regs[owd_pkg::REG_DELAY]   = owd_pkg::DELAY_RESET;
        cfg_regs[owd_pkg::REG_DLOW]    = owd_pkg::DLOW_RESET;
        cfg_regs[owd_pkg::REG_WINDOW]  = owd_pkg::WINDOW_RESET;
        cfg_regs[owd_pkg::REG_GAP]     = owd_pkg::GAP_RESET;
        cfg_regs[owd_pkg::REG_ADDRESS] = {4'd0, owd_pkg::ADDR_RESET};
        line_pin     = 1'b0;
        frame_busy   = 1'b0;
        seg_num      = 0;
        seg_ticks    = '0;
        frame_level  = '0;
        powered      = 1'b1;
        wake_bright  = '0;
        latest_level = '0;
    endfunction

    // ------------------------------------------------------------------
    // Command driver. Works in bursts with random gaps; now and then it
    // waits until every outstanding result has come back.
    // ------------------------------------------------------------------
    owd_pkg::item_t   commands [$];
    owd_pkg::result_t expected_lines [$];
    owd_pkg::item_t   on_bus;
    int               burst_left;
    int               gap_left;
    logic             drain_hold;
    logic             offer;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= owd_pkg::OP_TICK;
            burst_left = 0;
            gap_left   = 0;
            drain_hold = 1'b0;
            offer      = 1'b0;
            on_bus     = '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_lines.push_back(line_step(on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                offer = 1'b0;
                if (drain_hold)
                begin
                    if (expected_lines.size() == 0)
                        drain_hold = 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (commands.size() > 0)
                begin
                    on_bus = commands.pop_front();
                    offer  = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = int'($urandom_range(1, 24));
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                 : int'($urandom_range(1, 5));
                        drain_hold = ($urandom_range(0, 11) == 0);
                    end
                end
                // Exactly one update of each bus signal per edge.
                s_axis_tvalid <= offer;
                s_axis_tdata  <= {7'd0, on_bus.blanked, on_bus.brightness};
                s_axis_tuser  <= on_bus.op;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Checks each beat against the oldest expectation and
    // drives tready on a stall pattern of its own, with a long hold-off now
    // and then so that the block backs up into its input.
    // ------------------------------------------------------------------
    int               errors = 0;
    int               beats_seen;
    int               hold_left;
    int               mode_left;
    int               ready_mode;
    logic             rdy;
    owd_pkg::result_t got;
    owd_pkg::result_t want;

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            beats_seen = 0;
            hold_left  = 0;
            mode_left  = 0;
            ready_mode = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = owd_pkg::result_t'(m_axis_tdata);
                if (expected_lines.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    check_field("pin", int'(want.pin), int'(got.pin));
                    check_field("accepted", int'(want.accepted), int'(got.accepted));
                    check_field("busy_res", int'(want.busy_res), int'(got.busy_res));
                    check_field("sent_level", int'(want.sent_level), int'(got.sent_level));
                end
                beats_seen++;
                if (beats_seen % 400 == 200)
                    hold_left = 48;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = int'($urandom_range(0, 3));
                    mode_left  = 16;
                end
                mode_left--;
                case (ready_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = ($urandom_range(0, 1) == 1);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    int queued_total = 0;

    task automatic push_cmd(input owd_pkg::op_t op, input logic [7:0] b, input logic blank);
        owd_pkg::item_t c;
        c.op         = op;
        c.brightness = b;
        c.blanked    = blank;
        commands.push_back(c);
        queued_total++;
    endtask

    task automatic push_random();
        push_cmd(owd_pkg::op_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    endtask

    // Ticks carry random payload; the block must ignore it.
    task automatic tick_run(input int n);
        for (int i = 0; i < n; i++)
            push_cmd(owd_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // The driver may have taken a command off the queue in this very step
    // without its valid showing yet, so its own offer flag counts as well.
    task automatic wait_drained();
        while (commands.size() != 0 || offer || s_axis_tvalid || expected_lines.size() != 0)
            @(posedge clk);
    endtask

    // Let any frame run out, then wait for every result so a write is safe.
    task automatic finish_phase();
        tick_run(frame_span());
        wait_drained();
    endtask

    task automatic write_reg(input owd_pkg::cfg_idx_t idx, input logic [11:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_regs[idx] = (idx == owd_pkg::REG_ADDRESS) ? (val & 12'h0FF) : val;
    endtask

    task automatic write_timing(input logic [11:0] short_v, input logic [11:0] long_v,
                                input logic [11:0] eos_v, input logic [11:0] delay_v,
                                input logic [11:0] dlow_v, input logic [11:0] window_v,
                                input logic [11:0] gap_v, input logic [11:0] addr_v);
        write_reg(owd_pkg::REG_SHORT, short_v);
        write_reg(owd_pkg::REG_LONG, long_v);
        write_reg(owd_pkg::REG_EOS, eos_v);
        write_reg(owd_pkg::REG_DELAY, delay_v);
        write_reg(owd_pkg::REG_DLOW, dlow_v);
        write_reg(owd_pkg::REG_WINDOW, window_v);
        write_reg(owd_pkg::REG_GAP, gap_v);
        write_reg(owd_pkg::REG_ADDRESS, addr_v);
    endtask

    // Mostly tiny durations so frames stay short; zero shows up often.
    function automatic logic [11:0] small_time();
        return ($urandom_range(0, 7) == 0) ? 12'($urandom_range(7, 40))
                                           : 12'($urandom_range(0, 6));
    endfunction

    task automatic random_config();
        write_timing(small_time(), small_time(), small_time(), small_time(),
                     small_time(), small_time(), small_time(), 12'($urandom_range(0, 4095)));
    endtask

    // Brightness with a bias toward the edges of the level mapping.
    function automatic logic [7:0] pick_brightness();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 8))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd14;
            3:       return 8'd15;
            4:       return 8'd16;
            5:       return 8'd22;
            6:       return 8'd23;
            7:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // One well-formed sequence with random content, or a little noise.
    task automatic random_episode();
        int kind;
        int n;
        int poke;
        kind = int'($urandom_range(0, 9));
        if (kind <= 5)
        begin
            push_cmd(owd_pkg::OP_SET, pick_brightness(), $urandom_range(0, 7) == 0);
            n    = int'($urandom_range(frame_span() / 2, frame_span() + 3));
            poke = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, n)) : -1;
            for (int i = 0; i < n; i++)
            begin
                if (i == poke)
                    push_random();
                push_cmd(owd_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end
        end
        else if (kind == 6)
        begin
            push_cmd(owd_pkg::OP_SUSPEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 2))
                push_cmd(owd_pkg::OP_SET, pick_brightness(), $urandom_range(0, 3) == 0);
            push_cmd(owd_pkg::OP_RESUME, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            tick_run(frame_span());
        end
        else if (kind == 7)
        begin
            push_cmd(owd_pkg::OP_RESUME, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            tick_run(frame_span());
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                push_random();
        end
    endtask

    int random_start;
    int phase_start;

    initial
    begin
        reset_line_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset timing: commands that never start a frame. A tick while
        // idle changes nothing, zero and blanked sets pull the line low, a
        // set while suspended is only stored, and resume applies it.
        push_cmd(owd_pkg::OP_TICK, 8'hFF, 1'b1);
        push_cmd(owd_pkg::OP_SET, 8'd0, 1'b0);
        push_cmd(owd_pkg::OP_SET, 8'd255, 1'b1);
        push_cmd(owd_pkg::OP_SUSPEND, 8'd0, 1'b0);
        push_cmd(owd_pkg::OP_SET, 8'd200, 1'b0);
        push_cmd(owd_pkg::OP_SET, 8'd0, 1'b0);
        push_cmd(owd_pkg::OP_RESUME, 8'd0, 1'b0);
        push_cmd(owd_pkg::OP_TICK, 8'd0, 1'b0);
        wait_drained();

        // Shortest timing: zero writes must behave as one tick. The address
        // write carries junk above bit 7 that the block must drop.
        write_timing(12'd0, 12'd1, 12'd0, 12'd1, 12'd0, 12'd1, 12'd0, 12'hFFF);
        push_cmd(owd_pkg::OP_SET, 8'd14, 1'b0);      // below the floor: level zero frame
        tick_run(3);
        push_cmd(owd_pkg::OP_SET, 8'd255, 1'b0);     // all refused while the frame runs
        push_cmd(owd_pkg::OP_SUSPEND, 8'd0, 1'b0);
        push_cmd(owd_pkg::OP_RESUME, 8'd0, 1'b0);
        tick_run(frame_span());
        push_cmd(owd_pkg::OP_SET, 8'd15, 1'b0);
        tick_run(frame_span());
        push_cmd(owd_pkg::OP_SET, 8'd255, 1'b0);
        tick_run(frame_span());
        push_cmd(owd_pkg::OP_SET, 8'd23, 1'b0);
        tick_run(frame_span());
        push_cmd(owd_pkg::OP_SET, 8'd254, 1'b1);     // blanked while powered
        push_cmd(owd_pkg::OP_SUSPEND, 8'd0, 1'b0);
        push_cmd(owd_pkg::OP_SET, 8'd255, 1'b0);     // stored for wake-up
        push_cmd(owd_pkg::OP_RESUME, 8'd0, 1'b0);    // sends the stored level
        finish_phase();

        // Long framing segments with the shortest data bits.
        write_timing(12'd0, 12'd1, 12'd21, 12'd17, 12'd25, 12'd30, 12'd19, 12'h000);
        push_cmd(owd_pkg::OP_SET, 8'd100, 1'b0);
        tick_run(5);
        push_cmd(owd_pkg::OP_SET, 8'd1, 1'b0);
        finish_phase();

        // Long data bits with the shortest framing segments.
        write_timing(12'd5, 12'd9, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'hA5);
        push_cmd(owd_pkg::OP_SET, 8'd22, 1'b0);
        finish_phase();

        // Random sequences under a series of random small timings.
        random_start = queued_total;
        while (queued_total - random_start < RANDOM_ITEMS)
        begin
            random_config();
            phase_start = queued_total;
            while (queued_total - phase_start < PHASE_ITEMS)
                random_episode();
            finish_phase();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
